FILE: hw/rtl/lpfd_pkg.sv
// Package for the length-prefixed frame deframer.
// Holds phase codes, result kind codes and fixed widths; no dependencies.
package lpfd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned PHASE_W    = 2;
	localparam int unsigned HDR_IDX_W  = 3;
	localparam int unsigned OUT_DATA_W = BYTE_W + BYTE_W + LEN_W;

	localparam logic [HDR_IDX_W-1:0] HDR_TYPE_POS = 3'd4;

	localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd1;
	localparam logic [PHASE_W-1:0] PH_HALTED  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 32'd1048576;

	typedef logic [KIND_W-1:0] kind_t;

endpackage

FILE: hw/rtl/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer, top level.
// Depends on lpfd_pkg for phase and kind codes.
//
// Takes one byte per beat, one beat per cycle while s_tready is high. Each
// frame is a 5-byte header (4-byte little-endian payload length, then a
// type byte) and its payload. On the type byte the length is checked against
// max_payload: an oversize length gives one error beat and the block then
// drops every byte until reset; a zero length gives one empty-frame beat;
// otherwise each payload byte leaves as one beat with type, length and
// tlast on the final byte. A byte's result reaches the master side in the
// cycle after the byte is taken; the single result register holds while
// m_tready is low and s_tready is high whenever it is empty or being drained,
// so the block sustains one byte per cycle, no bubbles, while m_tready is high.
module length_prefixed_frame_deframer_top
	import lpfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [LEN_W-1:0]      cfg_wr_data,      // max_payload
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,          // in_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,          // frame_type, data_byte, frame_length
	output logic [KIND_W-1:0]     m_tuser,          // kind
	output logic                  m_tlast           // last_of_frame
);

	logic [LEN_W-1:0]     max_payload_q;
	logic [PHASE_W-1:0]   phase_q, phase_d;
	logic [HDR_IDX_W-1:0] hdr_idx_q, hdr_idx_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [LEN_W-1:0]     remain_q, remain_d;
	logic [BYTE_W-1:0]    type_q, type_d;

	logic                 accept;
	logic                 res_valid;
	kind_t                res_kind;
	logic [BYTE_W-1:0]    res_data;
	logic                 res_last;
	logic [LEN_W-1:0]     remain_dec;

	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [BYTE_W-1:0]    out_type_q;
	logic [BYTE_W-1:0]    out_data_q;
	logic [LEN_W-1:0]     out_len_q;
	logic                 out_last_q;

	assign s_tready   = !out_valid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign remain_dec = remain_q - 1'b1;

	always_comb begin
		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		len_d     = len_q;
		remain_d  = remain_q;
		type_d    = type_q;
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_data  = '0;
		res_last  = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_idx_q < HDR_TYPE_POS) begin
					case (hdr_idx_q[1:0])
						2'd0: len_d = {{(LEN_W-BYTE_W){1'b0}}, s_tdata};
						2'd1: len_d[15:8]  = s_tdata;
						2'd2: len_d[23:16] = s_tdata;
						2'd3: len_d[31:24] = s_tdata;
						default: len_d = len_q;
					endcase
					hdr_idx_d = hdr_idx_q + 1'b1;
				end else begin
					type_d    = s_tdata;
					hdr_idx_d = '0;
					if (len_q > max_payload_q) begin
						phase_d   = PH_HALTED;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_last  = 1'b1;
					end else if (len_q == '0) begin
						res_valid = 1'b1;
						res_kind  = KIND_EMPTY;
						res_last  = 1'b1;
					end else begin
						remain_d = len_q;
						phase_d  = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				remain_d  = remain_dec;
				res_valid = 1'b1;
				res_kind  = KIND_DATA;
				res_data  = s_tdata;
				res_last  = (remain_dec == '0);
				if (remain_dec == '0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
			phase_q       <= PH_HEADER;
			hdr_idx_q     <= '0;
			len_q         <= '0;
			remain_q      <= '0;
			type_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_payload_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q   <= phase_d;
				hdr_idx_q <= hdr_idx_d;
				len_q     <= len_d;
				remain_q  <= remain_d;
				type_q    <= type_d;
			end
			if (s_tready) begin
				out_valid_q <= accept && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_kind_q <= res_kind;
			out_type_q <= type_d;
			out_data_q <= res_data;
			out_len_q  <= len_d;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_data_q, out_type_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALTED |=> phase_q == PH_HALTED)
		else $error("halted phase left before reset");

	a_payload_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remain_q != '0)
		else $error("payload phase with zero bytes remaining");

	a_hdr_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_idx_q <= HDR_TYPE_POS)
		else $error("header index beyond type byte");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && m_tuser == KIND_ERROR |-> phase_q == PH_HALTED && m_tlast)
		else $error("error beat without halt or tlast");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result register changed while stalled");

endmodule
